### src/crss_pkg.sv
`timescale 1ns / 1ps
// shared types, widths and constants of the catmull-rom segment sampler
// no dependencies; imported by every module of the block

package crss_pkg;

   // field and datapath widths
   localparam int PT_W   = 32;             // Q15.16 point coordinate
   localparam int T_W    = 16;             // Q0.16 curve parameter
   localparam int A_W    = 33;             // p2 - p0
   localparam int B_W    = 36;             // 2p0 - 5p1 + 4p2 - p3
   localparam int C_W    = 35;             // -p0 + 3p1 - 3p2 + p3
   localparam int H_W    = 39;             // horner accumulator, bounded below 2^38
   localparam int PROD_W = H_W + T_W + 1;  // accumulator times zero-extended t
   localparam int N_W    = 6;              // sample count register
   localparam int CNT_W  = 8;              // point count and max_points
   localparam int REM_W  = 5;              // remainder of the t stepping

   localparam int MAX_SEG_SAMPLES = 32;
   localparam int MAX_VERTS       = 256;
   localparam int FIFO_DEPTH      = 2;

   // configuration port
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_SEG_SAMPLES = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_POINTS  = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CLOSED_LOOP = 8'd2;

   // polynomial coefficients of one axis, plus the segment end points
   typedef struct packed {
      logic signed [A_W-1:0]  a;
      logic signed [B_W-1:0]  b;
      logic signed [C_W-1:0]  c;
      logic signed [PT_W-1:0] p1;
      logic signed [PT_W-1:0] p2;
   } axis_coef_type;

   // one queued segment
   typedef struct packed {
      logic          first;
      logic          last;
      axis_coef_type x;
      axis_coef_type y;
   } seg_type;

   typedef struct packed {
      logic [N_W-1:0]   seg_samples;
      logic [CNT_W-1:0] max_points;
      logic             closed_loop;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MUL,
      ST_ACC,
      ST_EMIT,
      ST_END
   } state_type;

   // t increment for n samples: 65536 = q * n + r
   typedef struct packed {
      logic [T_W:0]     q;
      logic [REM_W-1:0] r;
   } step_type;

   function automatic step_type step_of(input logic [N_W-1:0] n);
      step_type st;
      case (n)
         6'd2:    st = '{q: 17'd32768, r: 5'd0};
         6'd3:    st = '{q: 17'd21845, r: 5'd1};
         6'd4:    st = '{q: 17'd16384, r: 5'd0};
         6'd5:    st = '{q: 17'd13107, r: 5'd1};
         6'd6:    st = '{q: 17'd10922, r: 5'd4};
         6'd7:    st = '{q: 17'd9362,  r: 5'd2};
         6'd8:    st = '{q: 17'd8192,  r: 5'd0};
         6'd9:    st = '{q: 17'd7281,  r: 5'd7};
         6'd10:   st = '{q: 17'd6553,  r: 5'd6};
         6'd11:   st = '{q: 17'd5957,  r: 5'd9};
         6'd12:   st = '{q: 17'd5461,  r: 5'd4};
         6'd13:   st = '{q: 17'd5041,  r: 5'd3};
         6'd14:   st = '{q: 17'd4681,  r: 5'd2};
         6'd15:   st = '{q: 17'd4369,  r: 5'd1};
         6'd16:   st = '{q: 17'd4096,  r: 5'd0};
         6'd17:   st = '{q: 17'd3855,  r: 5'd1};
         6'd18:   st = '{q: 17'd3640,  r: 5'd16};
         6'd19:   st = '{q: 17'd3449,  r: 5'd5};
         6'd20:   st = '{q: 17'd3276,  r: 5'd16};
         6'd21:   st = '{q: 17'd3120,  r: 5'd16};
         6'd22:   st = '{q: 17'd2978,  r: 5'd20};
         6'd23:   st = '{q: 17'd2849,  r: 5'd9};
         6'd24:   st = '{q: 17'd2730,  r: 5'd16};
         6'd25:   st = '{q: 17'd2621,  r: 5'd11};
         6'd26:   st = '{q: 17'd2520,  r: 5'd16};
         6'd27:   st = '{q: 17'd2427,  r: 5'd7};
         6'd28:   st = '{q: 17'd2340,  r: 5'd16};
         6'd29:   st = '{q: 17'd2259,  r: 5'd25};
         6'd30:   st = '{q: 17'd2184,  r: 5'd16};
         6'd31:   st = '{q: 17'd2114,  r: 5'd2};
         6'd32:   st = '{q: 17'd2048,  r: 5'd0};
         default: st = '{q: 17'd65536, r: 5'd0};  // one sample
      endcase
      return st;
   endfunction

endpackage

### src/crss_front.sv
`timescale 1ns / 1ps
// front end: accepts segment beats and turns control points into coefficients
// depends on crss_pkg; feeds crss_fifo

module crss_front (
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [crss_pkg::PT_W-1:0]  req_p0_x,
   input  logic signed [crss_pkg::PT_W-1:0]  req_p0_y,
   input  logic signed [crss_pkg::PT_W-1:0]  req_p1_x,
   input  logic signed [crss_pkg::PT_W-1:0]  req_p1_y,
   input  logic signed [crss_pkg::PT_W-1:0]  req_p2_x,
   input  logic signed [crss_pkg::PT_W-1:0]  req_p2_y,
   input  logic signed [crss_pkg::PT_W-1:0]  req_p3_x,
   input  logic signed [crss_pkg::PT_W-1:0]  req_p3_y,
   input  logic                              req_first_segment,
   input  logic                              req_last_segment,
   input  logic                              fifo_full,
   output logic                              fifo_push,
   output crss_pkg::seg_type                 fifo_entry
);
   import crss_pkg::*;

   // exact cubic coefficients of one axis
   function automatic axis_coef_type coef_of(
      input logic signed [PT_W-1:0] q0,
      input logic signed [PT_W-1:0] q1,
      input logic signed [PT_W-1:0] q2,
      input logic signed [PT_W-1:0] q3
   );
      axis_coef_type r;
      r.a  = A_W'(q2) - A_W'(q0);
      r.b  = (B_W'(q0) <<< 1) - (B_W'(q1) <<< 2) - B_W'(q1)
           + (B_W'(q2) <<< 2) - B_W'(q3);
      r.c  = C_W'(q3) - C_W'(q0)
           + (C_W'(q1) <<< 1) + C_W'(q1) - (C_W'(q2) <<< 1) - C_W'(q2);
      r.p1 = q1;
      r.p2 = q2;
      return r;
   endfunction

   // take a beat whenever the queue has room
   assign req_ready = !fifo_full;
   assign fifo_push = req_valid && !fifo_full;

   // queue entry
   always_comb begin
      fifo_entry.first = req_first_segment;
      fifo_entry.last  = req_last_segment;
      fifo_entry.x     = coef_of(req_p0_x, req_p1_x, req_p2_x, req_p3_x);
      fifo_entry.y     = coef_of(req_p0_y, req_p1_y, req_p2_y, req_p3_y);
   end

endmodule

### src/crss_fifo.sv
`timescale 1ns / 1ps
// short segment queue between the front and back ends
// depends on crss_pkg

module crss_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  crss_pkg::seg_type wr_data,
   output logic              full,
   input  logic              pop,
   output logic              rd_valid,
   output crss_pkg::seg_type rd_data
);
   import crss_pkg::*;

   localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int OCC_W = $clog2(FIFO_DEPTH + 1);

   seg_type            mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [OCC_W-1:0]   occ_ff, occ_in;
   logic               do_push, do_pop;

   assign full     = (occ_ff == OCC_W'(FIFO_DEPTH));
   assign rd_valid = (occ_ff != '0);
   assign rd_data  = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && rd_valid;

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      occ_in    = occ_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         occ_in = occ_ff + OCC_W'(1);
      end else if (do_pop && !do_push) begin
         occ_in = occ_ff - OCC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         occ_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         occ_ff    <= occ_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

### src/crss_back.sv
`timescale 1ns / 1ps
// back end: sample sequencer, horner evaluation on x and y lanes, point cap
// and output register; depends on crss_pkg, reads entries from crss_fifo

module crss_back (
   input  logic                             clock,
   input  logic                             reset,
   input  crss_pkg::cfg_type                cfg,
   input  logic                             seg_valid,
   input  crss_pkg::seg_type                seg,
   output logic                             seg_pop,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [crss_pkg::PT_W-1:0] rsp_pt_x,
   output logic signed [crss_pkg::PT_W-1:0] rsp_pt_y,
   output logic                             rsp_run_last
);
   import crss_pkg::*;

   state_type                 state_ff, state_in;
   seg_type                   seg_ff, seg_in;
   logic [N_W-1:0]            s_ff, s_in;
   logic [T_W:0]              t_ff, t_in;
   logic [REM_W-1:0]          r_ff, r_in;
   logic [1:0]                step_ff, step_in;
   logic signed [H_W-1:0]     hx_ff, hx_in, hy_ff, hy_in;
   logic signed [PROD_W-1:0]  px_ff, px_in, py_ff, py_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [PT_W-1:0]    pt_x_ff, pt_x_in, pt_y_ff, pt_y_in;
   logic                      run_last_ff, run_last_in;

   logic [N_W-1:0]            n_eff;
   logic [CNT_W-1:0]          cap;
   step_type                  tstep;
   logic [REM_W:0]            r_sum;
   logic [CNT_W-1:0]          next_count;
   logic                      out_free, cap_hit, last_sample, end_follows;
   logic                      start_eval, do_mul, do_acc, emit_pt, emit_end;
   logic signed [H_W-1:0]     add_x, add_y;
   logic signed [T_W:0]       t_op;

   // halve and saturate the final horner value
   function automatic logic signed [PT_W-1:0] sat_half(input logic signed [H_W-1:0] h);
      logic signed [H_W-2:0] v;
      logic signed [PT_W-1:0] r;
      v = h[H_W-1:1];
      if ((&v[H_W-2:PT_W-1]) || !(|v[H_W-2:PT_W-1])) begin
         r = v[PT_W-1:0];
      end else if (v[H_W-2]) begin
         r = {1'b1, {(PT_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(PT_W-1){1'b1}}};
      end
      return r;
   endfunction

   // effective sample count and point cap
   always_comb begin
      if (cfg.seg_samples == '0) begin
         n_eff = N_W'(1);
      end else if (cfg.seg_samples > N_W'(MAX_SEG_SAMPLES)) begin
         n_eff = N_W'(MAX_SEG_SAMPLES);
      end else begin
         n_eff = cfg.seg_samples;
      end
      cap = (cfg.max_points > CNT_W'(MAX_VERTS - 1)) ? CNT_W'(MAX_VERTS - 1)
                                                    : cfg.max_points;
   end

   assign tstep       = step_of(n_eff);
   assign r_sum       = {1'b0, r_ff} + {1'b0, tstep.r};
   assign next_count  = count_ff + CNT_W'(1);
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign cap_hit     = (count_ff >= cap);
   assign last_sample = (s_ff == n_eff - N_W'(1)) || (next_count >= cap);
   assign end_follows = seg_ff.last && !cfg.closed_loop && (next_count < cap);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (seg_valid) state_in = ST_CHECK;
         ST_CHECK: state_in = cap_hit ? ST_IDLE : ST_MUL;
         ST_MUL:   state_in = ST_ACC;
         ST_ACC:   state_in = (step_ff == 2'd2) ? ST_EMIT : ST_MUL;
         ST_EMIT: begin
            if (out_free) begin
               if (!last_sample) begin
                  state_in = ST_MUL;
               end else begin
                  state_in = end_follows ? ST_END : ST_IDLE;
               end
            end
         end
         ST_END:   if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      seg_pop    = 1'b0;
      start_eval = 1'b0;
      do_mul     = 1'b0;
      do_acc     = 1'b0;
      emit_pt    = 1'b0;
      emit_end   = 1'b0;
      case (state_ff)
         ST_IDLE:  seg_pop = seg_valid;
         ST_CHECK: start_eval = !cap_hit;
         ST_MUL:   do_mul = 1'b1;
         ST_ACC:   do_acc = 1'b1;
         ST_EMIT: begin
            emit_pt    = out_free;
            start_eval = out_free && !last_sample;
         end
         ST_END:   emit_end = out_free;
         default: begin
            seg_pop = 1'b0;
         end
      endcase
   end

   // horner addend for the current step
   always_comb begin
      case (step_ff)
         2'd0: begin
            add_x = H_W'(seg_ff.x.b);
            add_y = H_W'(seg_ff.y.b);
         end
         2'd1: begin
            add_x = H_W'(seg_ff.x.a);
            add_y = H_W'(seg_ff.y.a);
         end
         default: begin
            add_x = H_W'(seg_ff.x.p1) <<< 1;
            add_y = H_W'(seg_ff.y.p1) <<< 1;
         end
      endcase
   end

   assign t_op = $signed({1'b0, t_ff[T_W-1:0]});

   // datapath next values
   always_comb begin
      seg_in       = seg_ff;
      s_in         = s_ff;
      t_in         = t_ff;
      r_in         = r_ff;
      step_in      = step_ff;
      hx_in        = hx_ff;
      hy_in        = hy_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      count_in     = count_ff;
      pt_x_in      = pt_x_ff;
      pt_y_in      = pt_y_ff;
      run_last_in  = run_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      // new segment: restart sampling, new curve clears the count
      if (seg_pop) begin
         seg_in   = seg;
         s_in     = '0;
         t_in     = '0;
         r_in     = '0;
         count_in = seg.first ? '0 : count_ff;
      end

      // load the cubic coefficient for a new point
      if (start_eval) begin
         hx_in   = H_W'(seg_ff.x.c);
         hy_in   = H_W'(seg_ff.y.c);
         step_in = '0;
      end

      if (do_mul) begin
         px_in = hx_ff * t_op;
         py_in = hy_ff * t_op;
      end

      // floor shift of the product plus the next coefficient
      if (do_acc) begin
         hx_in   = $signed(px_ff[H_W+T_W-1:T_W]) + add_x;
         hy_in   = $signed(py_ff[H_W+T_W-1:T_W]) + add_y;
         step_in = step_ff + 2'd1;
      end

      // sampled point into the output register, step t
      if (emit_pt) begin
         pt_x_in      = sat_half(hx_ff);
         pt_y_in      = sat_half(hy_ff);
         run_last_in  = last_sample && !end_follows;
         rsp_valid_in = 1'b1;
         count_in     = next_count;
         s_in         = s_ff + N_W'(1);
         if (r_sum >= {1'b0, n_eff[REM_W-1:0]} || n_eff[N_W-1]) begin
            if (r_sum >= (REM_W+1)'(n_eff)) begin
               r_in = REM_W'(r_sum - (REM_W+1)'(n_eff));
               t_in = t_ff + tstep.q + (T_W+1)'(1);
            end else begin
               r_in = r_sum[REM_W-1:0];
               t_in = t_ff + tstep.q;
            end
         end else begin
            r_in = r_sum[REM_W-1:0];
            t_in = t_ff + tstep.q;
         end
      end

      // open path end point
      if (emit_end) begin
         pt_x_in      = seg_ff.x.p2;
         pt_y_in      = seg_ff.y.p2;
         run_last_in  = 1'b1;
         rsp_valid_in = 1'b1;
         count_in     = next_count;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      seg_ff      <= seg_in;
      s_ff        <= s_in;
      t_ff        <= t_in;
      r_ff        <= r_in;
      hx_ff       <= hx_in;
      hy_ff       <= hy_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      pt_x_ff     <= pt_x_in;
      pt_y_ff     <= pt_y_in;
      run_last_ff <= run_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_pt_x     = pt_x_ff;
   assign rsp_pt_y     = pt_y_ff;
   assign rsp_run_last = run_last_ff;

   // a finished horner pass always goes to the emit step
   a_acc_to_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACC && step_ff == 2'd2) |=> state_ff == ST_EMIT)
      else $error("horner pass did not end in emit");

   // a point waiting on the output keeps its value
   a_emit_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && !out_free) |=> ($stable(hx_ff) && $stable(hy_ff)))
      else $error("stalled point changed");

   // every loaded beat bumps the point count by one
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (emit_pt || emit_end) |=> count_ff == CNT_W'($past(count_ff) + CNT_W'(1)))
      else $error("point count out of step");

   // a loaded point shows on the output next cycle
   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      (emit_pt || emit_end) |=> rsp_valid_ff)
      else $error("emitted point not valid");

endmodule

### src/catmull_rom_segment_sampler_top.sv
`timescale 1ns / 1ps
// Catmull-Rom segment sampler, top level: csr registers, front end, segment
// queue and back end; depends on crss_pkg, crss_front, crss_fifo, crss_back
//
// Each req beat is one uniform Catmull-Rom segment (four Q15.16 control
// points and first/last flags); the block returns n points (the sample count
// register) at t = s/n on rsp, plus p2 on the last segment of an open path,
// with rsp_run_last marking the final point of the segment and a per-curve
// count that stops output at max_points. The front end takes a beat per cycle,
// while the queue has room, into a two-entry queue. The back end evaluates x
// and y in parallel on one multiplier per axis with three multiply/accumulate
// steps per point; an appended end point gets its own output state.
// No clearing pass is needed after reset. The csr port is always ready and
// is to be written only while the block is idle.

module catmull_rom_segment_sampler_top (
   input  logic                                 clock,
   input  logic                                 reset,
   // segment channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [crss_pkg::PT_W-1:0]     req_p0_x,
   input  logic signed [crss_pkg::PT_W-1:0]     req_p0_y,
   input  logic signed [crss_pkg::PT_W-1:0]     req_p1_x,
   input  logic signed [crss_pkg::PT_W-1:0]     req_p1_y,
   input  logic signed [crss_pkg::PT_W-1:0]     req_p2_x,
   input  logic signed [crss_pkg::PT_W-1:0]     req_p2_y,
   input  logic signed [crss_pkg::PT_W-1:0]     req_p3_x,
   input  logic signed [crss_pkg::PT_W-1:0]     req_p3_y,
   input  logic                                 req_first_segment,
   input  logic                                 req_last_segment,
   // point channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [crss_pkg::PT_W-1:0]     rsp_pt_x,
   output logic signed [crss_pkg::PT_W-1:0]     rsp_pt_y,
   output logic                                 rsp_run_last,
   // configuration writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [crss_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [crss_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import crss_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   logic     fifo_full, fifo_push, fifo_pop, fifo_valid;
   seg_type  fifo_wr, fifo_rd;

   assign csr_ready = 1'b1;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SEG_SAMPLES: cfg_in.seg_samples = csr_wdata[N_W-1:0];
            CSR_MAX_POINTS:  cfg_in.max_points  = csr_wdata[CNT_W-1:0];
            CSR_CLOSED_LOOP: cfg_in.closed_loop = csr_wdata[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.seg_samples <= N_W'(1);
         cfg_ff.max_points  <= CNT_W'(128);
         cfg_ff.closed_loop <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front end
   crss_front u_front (
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_p0_x          (req_p0_x),
      .req_p0_y          (req_p0_y),
      .req_p1_x          (req_p1_x),
      .req_p1_y          (req_p1_y),
      .req_p2_x          (req_p2_x),
      .req_p2_y          (req_p2_y),
      .req_p3_x          (req_p3_x),
      .req_p3_y          (req_p3_y),
      .req_first_segment (req_first_segment),
      .req_last_segment  (req_last_segment),
      .fifo_full         (fifo_full),
      .fifo_push         (fifo_push),
      .fifo_entry        (fifo_wr)
   );

   // segment queue
   crss_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (fifo_push),
      .wr_data  (fifo_wr),
      .full     (fifo_full),
      .pop      (fifo_pop),
      .rd_valid (fifo_valid),
      .rd_data  (fifo_rd)
   );

   // back end
   crss_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .seg_valid    (fifo_valid),
      .seg          (fifo_rd),
      .seg_pop      (fifo_pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_pt_x     (rsp_pt_x),
      .rsp_pt_y     (rsp_pt_y),
      .rsp_run_last (rsp_run_last)
   );

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// testbench for catmull_rom_segment_sampler_top: queue-fed segment driver, point monitor and
// an in-line fixed-point spline predictor; depends on crss_pkg and the block's rtl only

module testbench;
   import crss_pkg::*;

   localparam int GAP_PCT        = 24;    // percent of cycles a side idles
   localparam int DRAIN_CYCLES   = 800;   // covers queued segments that emit nothing
   localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
   localparam int WATCHDOG_LIMIT = 5000;  // cycles with no beat on any channel
   localparam int PHASE_ITEMS    = 35;
   localparam int RANDOM_PHASES  = 10;
   localparam int STEADY_PHASE   = 3;
   localparam int SQUEEZE_PHASE  = 5;
   localparam int LONG_PHASE     = 7;

   localparam logic signed [PT_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [PT_W-1:0] COORD_MIN = 32'sh8000_0000;
   localparam longint SAT_HI = 64'sd2147483647;
   localparam longint SAT_LO = -64'sd2147483648;

   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_LO = CSR_CLOSED_LOOP + 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_HI = '1;

   typedef enum int { CS_WIDE, CS_LOCAL, CS_EDGE } coord_style_type;

   typedef struct {
      logic signed [PT_W-1:0] p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y;
      logic                   first, last;
   } segment_type;

   typedef struct {
      logic signed [PT_W-1:0] x, y;
      logic                   last;
   } point_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic signed [PT_W-1:0] req_p0_x = '0, req_p0_y = '0, req_p1_x = '0, req_p1_y = '0;
   logic signed [PT_W-1:0] req_p2_x = '0, req_p2_y = '0, req_p3_x = '0, req_p3_y = '0;
   logic                   req_first_segment = 1'b0;
   logic                   req_last_segment = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic signed [PT_W-1:0] rsp_pt_x, rsp_pt_y;
   logic                   rsp_run_last;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // predictor copy of the registers and the per-curve count
   logic [N_W-1:0]   spp_cfg;
   logic [CNT_W-1:0] max_points_cfg;
   logic             closed_cfg;
   int               curve_count;

   segment_type queued_segs[$];
   segment_type offered_seg;
   point_type   due_points[$];

   int  mismatches = 0;
   int  points_seen = 0;
   int  quiet_cycles = 0;
   int  hold_left = 0;
   bit  hold_done = 1'b0;
   bit  steady = 1'b0;
   bit  squeeze = 1'b0;

   catmull_rom_segment_sampler_top dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // one axis of the curve: horner in Q16 with floor shifts, then saturate
   function automatic logic signed [PT_W-1:0] curve_coord(longint q0, longint q1, longint q2,
                                                          longint q3, longint t);
      longint a, b, c, h;
      a = q2 - q0;
      b = 2 * q0 - 5 * q1 + 4 * q2 - q3;
      c = -q0 + 3 * q1 - 3 * q2 + q3;
      h = ((c * t) >>> 16) + b;
      h = ((h * t) >>> 16) + a;
      h = ((h * t) >>> 16) + 2 * q1;
      h = h >>> 1;
      if (h > SAT_HI)
         h = SAT_HI;
      if (h < SAT_LO)
         h = SAT_LO;
      return h[PT_W-1:0];
   endfunction

   // expected points of one accepted segment
   task automatic sample_segment(input segment_type sg);
      int        n, cap, s, got;
      longint    t;
      point_type pt;
      n = int'(spp_cfg);
      if (n < 1)
         n = 1;
      if (n > MAX_SEG_SAMPLES)
         n = MAX_SEG_SAMPLES;
      cap = int'(max_points_cfg);
      if (cap > MAX_VERTS - 1)
         cap = MAX_VERTS - 1;
      if (sg.first)
         curve_count = 0;
      got = 0;
      for (s = 0; s < n && curve_count < cap; s++) begin
         t = (longint'(s) << 16) / n;
         pt.x = curve_coord(sg.p0_x, sg.p1_x, sg.p2_x, sg.p3_x, t);
         pt.y = curve_coord(sg.p0_y, sg.p1_y, sg.p2_y, sg.p3_y, t);
         pt.last = 1'b0;
         due_points.push_back(pt);
         got++;
         curve_count++;
      end
      // open path: the last segment ends exactly on p2
      if (sg.last && !closed_cfg && curve_count < cap) begin
         pt.x = sg.p2_x;
         pt.y = sg.p2_y;
         pt.last = 1'b0;
         due_points.push_back(pt);
         got++;
         curve_count++;
      end
      if (got > 0) begin
         pt = due_points.pop_back();
         pt.last = 1'b1;
         due_points.push_back(pt);
      end
   endtask

   function automatic logic signed [PT_W-1:0] pick_coord(coord_style_type style);
      case (style)
         CS_WIDE:  return $urandom;
         CS_LOCAL: return 32'($urandom_range(0, 24'hFF_FFFF)) - 32'h0080_0000;
         default: begin
            case ($urandom_range(4))
               0:       return COORD_MAX;
               1:       return COORD_MIN;
               2:       return '0;
               3:       return '1;
               default: return $urandom;
            endcase
         end
      endcase
   endfunction

   task automatic add_seg(input logic signed [PT_W-1:0] x0, y0, x1, y1, x2, y2, x3, y3,
                          input logic first, last);
      segment_type sg;
      sg = '{x0, y0, x1, y1, x2, y2, x3, y3, first, last};
      queued_segs.push_back(sg);
   endtask

   // well-formed curve: sliding window of control points, first and last flagged
   task automatic queue_curve(input int nsegs, input coord_style_type style);
      logic signed [PT_W-1:0] wx[4], wy[4];
      int k, j;
      for (j = 0; j < 4; j++) begin
         wx[j] = pick_coord(style);
         wy[j] = pick_coord(style);
      end
      for (k = 0; k < nsegs; k++) begin
         add_seg(wx[0], wy[0], wx[1], wy[1], wx[2], wy[2], wx[3], wy[3],
                 k == 0, k == nsegs - 1);
         for (j = 0; j < 3; j++) begin
            wx[j] = wx[j+1];
            wy[j] = wy[j+1];
         end
         wx[3] = pick_coord(style);
         wy[3] = pick_coord(style);
      end
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      case (idx)
         CSR_SEG_SAMPLES: spp_cfg = data[N_W-1:0];
         CSR_MAX_POINTS:  max_points_cfg = data[CNT_W-1:0];
         CSR_CLOSED_LOOP: closed_cfg = data[0];
         default:         ;
      endcase
      csr_valid <= 1'b0;
   endtask

   // wait until every segment is taken and every point is back, then let the block drain
   task automatic settle();
      while (queued_segs.size() != 0 || req_valid || due_points.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] spp, maxp, closed);
      settle();
      write_reg(CSR_SEG_SAMPLES, spp);
      write_reg(CSR_MAX_POINTS, maxp);
      write_reg(CSR_CLOSED_LOOP, closed);
   endtask

   // segment driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            sample_segment(offered_seg);
         if (!req_valid || req_ready) begin
            if (queued_segs.size() != 0 && (steady || $urandom_range(99) >= GAP_PCT)) begin
               offered_seg = queued_segs.pop_front();
               req_valid <= 1'b1;
               req_p0_x <= offered_seg.p0_x;
               req_p0_y <= offered_seg.p0_y;
               req_p1_x <= offered_seg.p1_x;
               req_p1_y <= offered_seg.p1_y;
               req_p2_x <= offered_seg.p2_x;
               req_p2_y <= offered_seg.p2_y;
               req_p3_x <= offered_seg.p3_x;
               req_p3_y <= offered_seg.p3_y;
               req_first_segment <= offered_seg.first;
               req_last_segment <= offered_seg.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // point monitor and receiver pacing
   always @(posedge clock) begin
      point_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            points_seen++;
            if (due_points.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("point beat %0d with none expected: x=%0d y=%0d last=%0b",
                           points_seen, rsp_pt_x, rsp_pt_y, rsp_run_last);
            end else begin
               want = due_points.pop_front();
               if (rsp_pt_x !== want.x || rsp_pt_y !== want.y || rsp_run_last !== want.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("beat %0d: want x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                              points_seen, want.x, want.y, want.last,
                              rsp_pt_x, rsp_pt_y, rsp_run_last);
               end
            end
         end
         // one long hold-off while segments keep coming, so the input backs up
         if (!hold_done && squeeze && req_valid) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= steady || ($urandom_range(99) >= GAP_PCT);
         end
      end
   end

   // watchdog on cycles with no beat anywhere
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // stimulus
   initial begin
      int                     ph, r, count, len;
      logic [N_W-1:0]         spp;
      logic [CNT_W-1:0]       maxp;
      logic                   closed;
      coord_style_type        style;
      spp_cfg = 6'd1;
      max_points_cfg = 8'd128;
      closed_cfg = 1'b0;
      curve_count = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset settings: one sample per segment, p1 then p2 on a last segment
      add_seg('0, '0, '0, '0, '0, '0, '0, '0, 1'b1, 1'b1);
      add_seg(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
              COORD_MAX, COORD_MIN, 1'b1, 1'b1);

      // five samples (upper data bits dropped), full cap, open; unmapped indexes ignored
      settle();
      write_reg(CSR_SEG_SAMPLES, 8'hC5);
      write_reg(CSR_MAX_POINTS, 8'hFF);
      write_reg(CSR_CLOSED_LOOP, 8'hFE);
      write_reg(CSR_UNMAPPED_LO, 8'hFF);
      write_reg(CSR_UNMAPPED_HI, 8'h00);
      add_seg(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
              COORD_MAX, COORD_MAX, 1'b1, 1'b0);
      add_seg(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
              COORD_MIN, COORD_MIN, 1'b0, 1'b0);
      // alternating extremes drive the polynomial into saturation
      add_seg(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
              COORD_MAX, COORD_MIN, 1'b0, 1'b1);
      add_seg('1, 32'sd1, 32'sd1, '1, '1, 32'sd1, 32'sd1, '1, 1'b1, 1'b1);
      // curve continues without a first flag
      add_seg(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 32'sh0004_0000,
              32'sh0005_0000, -32'sh0006_0000, -32'sh0007_0000, 32'sh0008_8000,
              1'b0, 1'b0);
      add_seg(32'sh0003_0000, 32'sh0004_0000, 32'sh0005_0000, -32'sh0006_0000,
              -32'sh0007_0000, 32'sh0008_8000, 32'sh7FFF_0000, -32'sh7FFF_0000,
              1'b0, 1'b1);

      // zero samples acts as one, cap of three drops samples and end points
      configure(8'd0, 8'd3, 8'd0);
      add_seg(32'sd10, 32'sd20, 32'sd30, 32'sd40, 32'sd50, 32'sd60, 32'sd70, 32'sd80,
              1'b1, 1'b1);
      add_seg(32'sd11, 32'sd21, 32'sd31, 32'sd41, 32'sd51, 32'sd61, 32'sd71, 32'sd81,
              1'b0, 1'b1);
      add_seg(32'sd12, 32'sd22, 32'sd32, 32'sd42, 32'sd52, 32'sd62, 32'sd72, 32'sd82,
              1'b0, 1'b0);
      add_seg(32'sd13, 32'sd23, 32'sd33, 32'sd43, 32'sd53, 32'sd63, 32'sd73, 32'sd83,
              1'b1, 1'b1);

      // too many samples clamps to the maximum; a zero cap emits nothing
      configure(8'd63, 8'd0, 8'd0);
      add_seg(COORD_MAX, COORD_MIN, '0, '0, COORD_MIN, COORD_MAX, '1, '1, 1'b1, 1'b1);

      // closed mode ignores the last flag; cap lands mid segment
      configure(8'd63, 8'd40, 8'd1);
      add_seg(-32'sh0010_0000, 32'sh0000_0000, 32'sh0000_0000, 32'sh0010_0000,
              32'sh0010_0000, 32'sh0000_0000, 32'sh0000_0000, -32'sh0010_0000,
              1'b1, 1'b1);
      add_seg(32'sh0000_0000, 32'sh0010_0000, 32'sh0010_0000, 32'sh0000_0000,
              32'sh0000_0000, -32'sh0010_0000, -32'sh0010_0000, 32'sh0000_0000,
              1'b0, 1'b0);
      add_seg(32'sh0010_0000, 32'sh0000_0000, 32'sh0000_0000, -32'sh0010_0000,
              -32'sh0010_0000, 32'sh0000_0000, 32'sh0000_0000, 32'sh0010_0000,
              1'b0, 1'b1);

      // random phases: mostly well-formed curves, some stray segments
      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         r = $urandom_range(99);
         if (r < 60)
            spp = 6'($urandom_range(1, 8));
         else if (r < 70)
            spp = 6'd0;
         else if (r < 80)
            spp = 6'd32;
         else if (r < 90)
            spp = 6'($urandom_range(33, 63));
         else
            spp = 6'($urandom_range(9, 31));
         r = $urandom_range(99);
         if (r < 25)
            maxp = 8'd255;
         else if (r < 35)
            maxp = 8'd1;
         else if (r < 40)
            maxp = 8'd0;
         else
            maxp = 8'($urandom_range(2, 254));
         closed = 1'($urandom_range(1));
         if (ph == SQUEEZE_PHASE) begin
            spp = 6'd8;
            maxp = 8'd255;
            closed = 1'b0;
         end
         if (ph == LONG_PHASE) begin
            spp = 6'd32;
            maxp = 8'd255;
            closed = 1'b0;
         end
         configure({2'($urandom), spp}, maxp, {7'($urandom), closed});
         steady = (ph == STEADY_PHASE);
         squeeze = (ph == SQUEEZE_PHASE);
         count = 0;
         while (count < PHASE_ITEMS) begin
            style = coord_style_type'($urandom_range(2));
            if ($urandom_range(99) < 85) begin
               len = (ph == LONG_PHASE) ? 9 : $urandom_range(1, 6);
               queue_curve(len, style);
               count += len;
            end else begin
               add_seg(pick_coord(style), pick_coord(style), pick_coord(style),
                       pick_coord(style), pick_coord(style), pick_coord(style),
                       pick_coord(style), pick_coord(style),
                       1'($urandom_range(1)), 1'($urandom_range(1)));
               count++;
            end
         end
      end

      settle();
      steady = 1'b0;
      squeeze = 1'b0;
      if (due_points.size() != 0)
         mismatches++;
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
